@@ design/idm_pkg.sv @@
package idm_pkg;

    localparam int VALUE_BITS  = 64;
    localparam int RESULT_BITS = 32;
    localparam int CONST_BITS  = 32;
    localparam int HALF_BITS   = VALUE_BITS / 2;
    localparam int SHIFT_W     = 6;
    localparam int INDEX_W     = 2;

    // register indexes of the configuration port
    localparam logic [INDEX_W-1:0] CFG_MODE  = INDEX_W'(0);
    localparam logic [INDEX_W-1:0] CFG_CONST = INDEX_W'(1);

    typedef enum logic [1:0] {
        MODE_MOD = 2'd0,
        MODE_DIV = 2'd1,
        MODE_MUL = 2'd2
    } mode_t;

    // reciprocal of the constant: pow2 also covers a constant of zero
    typedef struct packed {
        logic                  pow2;
        logic [SHIFT_W-1:0]    shift;
        logic [VALUE_BITS-1:0] mult;
    } recip_t;

    // settings seen by the item pipeline
    typedef struct packed {
        mode_t                 mode;
        logic [CONST_BITS-1:0] divisor;
        recip_t                recip;
    } pipe_cfg_t;

endpackage

@@ design/invariant_divisor_mod_div_mul.sv @@
// an accepted item passes the product, high-half, quotient and result stages to m_tdata
// throughput: one item per cycle through the four-stage pipeline while m_tready and no derivation hold it
// writing the constant starts a reciprocal derivation (one quotient bit
// per cycle); s_tready stays low meanwhile, none for a power of two or zero
// reset (aresetn, synchronous, active low): mode modulo, constant 1, pipeline empty
module invariant_divisor_mod_div_mul import idm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [VALUE_BITS-1:0]  s_tdata,   // value[63:0]
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [RESULT_BITS-1:0] m_tdata,   // result[31:0]
    // configuration writes
    input  logic                   cfg_wen,
    input  logic [INDEX_W-1:0]     cfg_index,
    input  logic [CONST_BITS-1:0]  cfg_wdata
);

    mode_t                 mode_reg;
    logic [CONST_BITS-1:0] const_reg;
    logic                  const_we;
    recip_t                recip;
    logic                  busy;
    pipe_cfg_t             pipe_cfg;
    logic                  pipe_in_ready;

    // register file: mode and constant, writes beyond the list are dropped
    assign const_we = cfg_wen && (cfg_index == CFG_CONST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_MOD;
            const_reg <= CONST_BITS'(1);
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_MODE:  mode_reg  <= mode_t'(cfg_wdata[1:0]);
                CFG_CONST: const_reg <= cfg_wdata;
                default:   ;
            endcase
        end
    end

    // reciprocal derivation
    idm_recip u_recip (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .const_we   (const_we),
        .const_data (cfg_wdata),
        .recip      (recip),
        .busy       (busy)
    );

    always_comb begin
        pipe_cfg.mode    = mode_reg;
        pipe_cfg.divisor = const_reg;
        pipe_cfg.recip   = recip;
    end

    // items are held off while the reciprocal is being derived
    assign s_tready = pipe_in_ready && !busy;

    idm_pipe u_pipe (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (pipe_cfg),
        .in_valid   (s_tvalid && !busy),
        .in_ready   (pipe_in_ready),
        .in_value   (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (m_tdata)
    );

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready)
        else $error("item accepted during reciprocal derivation");

    a_derive_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (const_we && cfg_wdata != '0 && (cfg_wdata & (cfg_wdata - CONST_BITS'(1))) != '0)
        |=> busy)
        else $error("derivation did not start for a general constant");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule

@@ design/idm_recip.sv @@
module idm_recip import idm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  const_we,
    input  logic [CONST_BITS-1:0] const_data,
    output recip_t                recip,
    output logic                  busy
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    recip_t                recip_reg;
    logic                  busy_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CONST_BITS-1:0] rem_reg;
    logic [CONST_BITS-1:0] div_reg;
    logic [VALUE_BITS-1:0] quo_reg;

    logic [CONST_BITS-1:0] dm1;
    logic [SHIFT_W-1:0]    width;
    logic                  is_pow2;
    logic [CONST_BITS:0]   rem_start;
    logic [CONST_BITS:0]   r2;
    logic [CONST_BITS:0]   r2_sub;
    logic                  ge;
    logic [VALUE_BITS-1:0] quo_next;

    // bit width of c - 1, i.e. ceil(log2 c)
    always_comb begin
        dm1   = const_data - CONST_BITS'(1);
        width = '0;
        for (int i = 0; i < CONST_BITS; i++) begin
            if (dm1[i]) begin
                width = SHIFT_W'(i + 1);
            end
        end
        is_pow2   = (const_data & dm1) == '0;
        rem_start = ((CONST_BITS+1)'(1) << width) - {1'b0, const_data};
    end

    // one quotient bit of 2^64 * (2^l - c) / c per cycle
    always_comb begin
        r2       = {rem_reg, 1'b0};
        r2_sub   = r2 - {1'b0, div_reg};
        ge       = r2 >= {1'b0, div_reg};
        quo_next = {quo_reg[VALUE_BITS-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            cnt_reg         <= '0;
            recip_reg.pow2  <= 1'b1;
            recip_reg.shift <= '0;
            recip_reg.mult  <= '0;
        end else if (const_we) begin
            div_reg         <= const_data;
            rem_reg         <= rem_start[CONST_BITS-1:0];
            recip_reg.pow2  <= is_pow2;
            recip_reg.shift <= width;
            recip_reg.mult  <= '0;
            busy_reg        <= !is_pow2;
            cnt_reg         <= CNT_W'(VALUE_BITS);
        end else if (busy_reg) begin
            rem_reg <= ge ? r2_sub[CONST_BITS-1:0] : r2[CONST_BITS-1:0];
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg       <= 1'b0;
                recip_reg.mult <= quo_next + VALUE_BITS'(1);
            end
        end
    end

    assign recip = recip_reg;
    assign busy  = busy_reg;

endmodule

@@ design/idm_pipe.sv @@
module idm_pipe import idm_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pipe_cfg_t              cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_BITS-1:0]  in_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [RESULT_BITS-1:0] out_result
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    logic [VALUE_BITS-1:0]  x1_reg, x2_reg, x3_reg;
    logic [VALUE_BITS-1:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [VALUE_BITS-1:0]  t2_reg;
    logic [VALUE_BITS-1:0]  q3_reg;
    logic [RESULT_BITS-1:0] r4_reg;

    logic [HALF_BITS+1:0]   mid;
    logic [VALUE_BITS-1:0]  hi;
    logic [VALUE_BITS-1:0]  diff;
    logic [VALUE_BITS-1:0]  s;
    logic [SHIFT_W-1:0]     sh;
    logic [VALUE_BITS-1:0]  q;
    logic [RESULT_BITS-1:0] mul_a;
    logic [RESULT_BITS-1:0] prod;
    logic [RESULT_BITS-1:0] res;

    // a stage moves when it is empty or the next one moves
    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // stage 2: sum of the partial products, high half of m * x
    always_comb begin
        mid = (HALF_BITS+2)'(p00_reg[VALUE_BITS-1:HALF_BITS])
            + (HALF_BITS+2)'(p01_reg[HALF_BITS-1:0])
            + (HALF_BITS+2)'(p10_reg[HALF_BITS-1:0]);
        hi  = p11_reg
            + VALUE_BITS'(p01_reg[VALUE_BITS-1:HALF_BITS])
            + VALUE_BITS'(p10_reg[VALUE_BITS-1:HALF_BITS])
            + VALUE_BITS'(mid[HALF_BITS+1:HALF_BITS]);
    end

    // stage 3: quotient
    always_comb begin
        diff = x2_reg - t2_reg;
        s    = t2_reg + (diff >> 1);
        sh   = cfg.recip.shift - SHIFT_W'(1);
        if (cfg.divisor == '0) begin
            q = '0;
        end else if (cfg.recip.pow2) begin
            q = x2_reg >> cfg.recip.shift;
        end else begin
            q = s >> sh;
        end
    end

    // stage 4: remainder, quotient or product
    always_comb begin
        mul_a = (cfg.mode == MODE_MUL) ? x3_reg[RESULT_BITS-1:0] : q3_reg[RESULT_BITS-1:0];
        prod  = mul_a * cfg.divisor;
        case (cfg.mode)
            MODE_MOD: begin
                if (cfg.recip.pow2) begin
                    res = x3_reg[RESULT_BITS-1:0] & (cfg.divisor - CONST_BITS'(1));
                end else begin
                    res = x3_reg[RESULT_BITS-1:0] - prod;
                end
            end
            MODE_DIV: res = q3_reg[RESULT_BITS-1:0];
            MODE_MUL: res = prod;
            default:  res = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            x1_reg  <= in_value;
            p00_reg <= in_value[HALF_BITS-1:0] * cfg.recip.mult[HALF_BITS-1:0];
            p01_reg <= in_value[HALF_BITS-1:0] * cfg.recip.mult[VALUE_BITS-1:HALF_BITS];
            p10_reg <= in_value[VALUE_BITS-1:HALF_BITS] * cfg.recip.mult[HALF_BITS-1:0];
            p11_reg <= in_value[VALUE_BITS-1:HALF_BITS]
                       * cfg.recip.mult[VALUE_BITS-1:HALF_BITS];
        end
        if (en2) begin
            x2_reg <= x1_reg;
            t2_reg <= hi;
        end
        if (en3) begin
            x3_reg <= x2_reg;
            q3_reg <= q;
        end
        if (en4) begin
            r4_reg <= res;
        end
    end

    assign out_valid  = v4_reg;
    assign out_result = r4_reg;

endmodule

@@ test/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import idm_pkg::*;

    // indexes past the register list, writes to them must be dropped
    localparam logic [INDEX_W-1:0] CFG_SPARE_A = INDEX_W'(2);
    localparam logic [INDEX_W-1:0] CFG_SPARE_B = INDEX_W'(3);
    // mode code with no operation behind it
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 8;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [VALUE_BITS-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [RESULT_BITS-1:0] m_tdata;
    logic                   cfg_wen;
    logic [INDEX_W-1:0]     cfg_index;
    logic [CONST_BITS-1:0]  cfg_wdata;

    // shadow copy of the block's settings
    logic [1:0]            cur_mode;
    logic [CONST_BITS-1:0] cur_const;

    logic [RESULT_BITS-1:0] pending_results[$];
    int error_count;
    int quiet_cycles;
    int ready_hold;
    bit long_stalls;

    invariant_divisor_mod_div_mul i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // exact arithmetic: remainder, quotient or product, low 32 bits
    function automatic logic [RESULT_BITS-1:0] predict_result(logic [VALUE_BITS-1:0] x);
        logic [63:0] c;
        logic [63:0] r;
        c = {32'b0, cur_const};
        case (cur_mode)
            MODE_MOD: r = (c == 0) ? x : x % c;   // modulo by zero keeps the value
            MODE_DIV: r = (c == 0) ? 64'd0 : x / c;
            MODE_MUL: r = x * c;
            default:  r = 64'd0;                  // unused mode code
        endcase
        return r[RESULT_BITS-1:0];
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h (mode %0d const %h)",
                 what, got, want, cur_mode, cur_const);
        error_count++;
    endtask

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // operands around the interesting edges of the current constant
    function automatic logic [VALUE_BITS-1:0] pick_value();
        logic [63:0] k;
        k = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return 64'd0;
            1:       return '1;
            2:       return '1 - $urandom_range(0, 1000);
            3:       return 64'($urandom_range(0, 1000));
            4:       return 64'd1 << $urandom_range(0, 63);
            5:       return {32'b0, cur_const} * {32'b0, $urandom} + $urandom_range(0, 2) - 1;
            6:       return {32'b0, cur_const} * (k >> $urandom_range(32, 63))
                            + $urandom_range(0, 2) - 1;
            default: return k;
        endcase
    endfunction

    // one input item, called and returning at a falling edge
    task automatic send_value(logic [VALUE_BITS-1:0] x);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(predict_result(x));
        @(negedge aclk);
    endtask

    // let everything in flight come out before touching the registers
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(logic [INDEX_W-1:0] idx, logic [CONST_BITS-1:0] data);
        wait_idle();
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        if (idx == CFG_MODE) cur_mode = data[1:0];
        else if (idx == CFG_CONST) cur_const = data;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_op(logic [1:0] m, logic [CONST_BITS-1:0] c);
        write_reg(CFG_MODE, 32'(m));
        write_reg(CFG_CONST, c);
    endtask

    // reset values first, then zero, one, top bit, odd, all ones and every mode
    task automatic test_directed();
        send_value(64'd12345);
        send_value('1);
        set_op(MODE_MOD, 32'd0);
        send_value('1);
        set_op(MODE_DIV, 32'd0);
        send_value('1);
        set_op(MODE_MUL, 32'd0);
        send_value('1);
        set_op(MODE_MOD, 32'h8000_0000);
        send_value('1);
        send_value(64'h8000_0000_7fff_ffff);
        set_op(MODE_DIV, 32'h8000_0000);
        send_value('1);
        set_op(MODE_DIV, 32'd7);
        send_value('1);
        send_value(64'd6);
        send_value(64'd7);
        set_op(MODE_MOD, 32'hffff_ffff);
        send_value('1);
        send_value(64'hffff_fffe_0000_0001);
        set_op(MODE_DIV, 32'hffff_fffe);
        send_value('1);
        set_op(MODE_MUL, 32'hffff_ffff);
        send_value('1);
        send_value(64'd3);
        set_op(MODE_UNUSED, 32'd3);
        send_value('1);
        set_op(MODE_DIV, 32'd1);
        send_value(64'h0123_4567_89ab_cdef);
    endtask

    // writes to spare indexes must leave mode and constant alone
    task automatic test_spare_index();
        set_op(MODE_DIV, 32'd10);
        write_reg(CFG_SPARE_A, 32'd3);
        write_reg(CFG_SPARE_B, 32'hffff_ffff);
        send_value(64'd1000);
        send_value('1);
    endtask

    function automatic logic [CONST_BITS-1:0] pick_const();
        case ($urandom_range(0, 7))
            0:       return 32'(1) << $urandom_range(0, 31);
            1:       return 32'($urandom_range(0, 16));
            2:       return 32'hffff_ffff - $urandom_range(0, 3);
            // odd value shifted up: an even constant with a large power-of-two factor
            3:       return ($urandom | 32'd1) << $urandom_range(1, 24);
            4:       return 32'($urandom_range(3, 1000)) | 32'd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random();
        int ph;
        int n;
        int i;
        for (ph = 0; ph < 22; ph++) begin
            long_stalls = (ph % 4 == 3);
            set_op(2'($urandom_range(0, 2)), pick_const());
            n = (ph < 2) ? 10 : 25;
            for (i = 0; i < n; i++) begin
                send_value(pick_value());
                // sender holds back until the pipeline has emptied
                if (i == 12 && ph % 5 == 1) begin
                    s_tvalid <= 1'b0;
                    while (pending_results.size() != 0) @(negedge aclk);
                end
            end
        end
        long_stalls = 1'b0;
    endtask

    // receiver stalls: mostly single cycles, long holds in some phases
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            m_tready   <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (long_stalls && $urandom_range(0, 99) < 4) begin
            m_tready   <= 1'b0;
            ready_hold <= $urandom_range(10, 40);
        end else if ($urandom_range(0, 99) < 25) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checking against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", m_tdata, 32'h0);
            end else begin
                if (m_tdata !== pending_results[0])
                    report_mismatch("result", m_tdata, pending_results[0]);
                void'(pending_results.pop_front());
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL invariant_divisor_mod_div_mul");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_wen      = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        cur_mode     = MODE_MOD;
        cur_const    = 32'd1;
        error_count  = 0;
        quiet_cycles = 0;
        ready_hold   = 0;
        long_stalls  = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_spare_index();
        test_random();

        wait_idle();
        if (error_count == 0) begin
            $display("PASS invariant_divisor_mod_div_mul");
        end else begin
            $display("FAIL invariant_divisor_mod_div_mul");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
design/idm_pkg.sv
design/idm_recip.sv
design/idm_pipe.sv
design/invariant_divisor_mod_div_mul.sv
test/tb_top.sv
